/* design/lcsp_pkg.sv */
package lcsp_pkg;

	localparam int MAX_SERVERS = 16;
	localparam int MAX_CLIENTS = 1024;

	localparam int SRV_IW    = $clog2(MAX_SERVERS);
	localparam int SRV_CW    = $clog2(MAX_SERVERS + 1);
	localparam int LOAD_W    = 11;
	localparam int MAP_DEPTH = (MAX_CLIENTS < 1024) ? MAX_CLIENTS : 1024;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);

	localparam logic [1:0] KIND_REGISTER   = 2'd0;
	localparam logic [1:0] KIND_REQUEST    = 2'd1;
	localparam logic [1:0] KIND_DEREGISTER = 2'd2;
	localparam logic [1:0] KIND_RELEASE    = 2'd3;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_NO_SERVERS = 2'd1;
	localparam logic [1:0] STATUS_FULL       = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] server_addr;
		logic [15:0] server_port;
		logic [9:0]  client_id;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] chosen_addr;
		logic [15:0] chosen_port;
	} result_t;

	typedef struct packed {
		logic [31:0]       addr;
		logic [15:0]       port;
		logic [LOAD_W-1:0] load;
	} entry_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic              vld;
		logic              hit;
		logic [SRV_IW-1:0] hit_idx;
		logic              have;
		logic [LOAD_W-1:0] best_load;
		logic [SRV_IW-1:0] best_idx;
		logic [31:0]       best_addr;
		logic [15:0]       best_port;
	} scan_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_WRITE,
		CMD_INC,
		CMD_DEC,
		CMD_SHIFT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [SRV_IW-1:0] pos;
	} cmd_t;

	typedef struct packed {
		logic        mapped;
		logic [31:0] addr;
		logic [15:0] port;
	} map_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_KEY,
		ST_FIRE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

endpackage

/* design/lcsp_cell.sv */
module lcsp_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lcsp_pkg::SRV_IW-1:0] idx,
	input  logic [lcsp_pkg::SRV_CW-1:0] total,
	input  logic [31:0]                key_addr,
	input  logic [15:0]                key_port,
	input  lcsp_pkg::cmd_t             cmd,
	input  lcsp_pkg::entry_t           next_entry,
	input  lcsp_pkg::scan_t            carry_in,
	output lcsp_pkg::scan_t            carry_out,
	output lcsp_pkg::entry_t           entry
);

	lcsp_pkg::entry_t ent_q;
	lcsp_pkg::scan_t  carry_q;
	lcsp_pkg::scan_t  carry_d;
	logic             live;

	assign live      = 32'(idx) < 32'(total);
	assign entry     = ent_q;
	assign carry_out = carry_q;

	always_comb begin
		carry_d = carry_in;
		if (carry_in.vld && live) begin
			if (!carry_in.hit && ent_q.addr == key_addr && ent_q.port == key_port) begin
				carry_d.hit     = 1'b1;
				carry_d.hit_idx = idx;
			end
			// strict compare keeps the first of equal loads
			if (!carry_in.have || ent_q.load < carry_in.best_load) begin
				carry_d.have      = 1'b1;
				carry_d.best_load = ent_q.load;
				carry_d.best_idx  = idx;
				carry_d.best_addr = ent_q.addr;
				carry_d.best_port = ent_q.port;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			lcsp_pkg::CMD_WRITE: begin
				if (cmd.pos == idx) begin
					ent_q.addr <= key_addr;
					ent_q.port <= key_port;
					ent_q.load <= '0;
				end
			end
			lcsp_pkg::CMD_INC: begin
				if (cmd.pos == idx && ent_q.load != '1) begin
					ent_q.load <= ent_q.load + lcsp_pkg::LOAD_W'(1);
				end
			end
			lcsp_pkg::CMD_DEC: begin
				if (cmd.pos == idx && ent_q.load != '0) begin
					ent_q.load <= ent_q.load - lcsp_pkg::LOAD_W'(1);
				end
			end
			lcsp_pkg::CMD_SHIFT: begin
				// close the gap: take the neighbor's entry
				if (idx >= cmd.pos) begin
					ent_q <= next_entry;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* design/least_connections_server_picker.sv */
// Least-connections server picker. Every word (register, request, deregister
// or release) is taken only while the block is idle. A scan token walks the
// row of server cells one cell per cycle to find the matching entry and the
// first least-loaded one, and the update is then applied to all cells at
// once. One word is in work at a time; the next word can be taken once the
// result of the last is registered. A finished result waits in the output
// register while the next word is taken, and a further result holds the block
// until the output drains. After reset the client map is cleared one entry
// per cycle and item_stall stays high until that pass is done.
module least_connections_server_picker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lcsp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output lcsp_pkg::result_t result
);

	localparam int N = lcsp_pkg::MAX_SERVERS;

	lcsp_pkg::state_t  state_q, state_d;
	lcsp_pkg::item_t   item_q;
	logic [31:0]       key_addr_q;
	logic [15:0]       key_port_q;
	logic              mapped_q;
	logic [lcsp_pkg::SRV_CW-1:0] total_q, total_d;
	lcsp_pkg::scan_t   scan_q;
	logic              res_vld_q;
	lcsp_pkg::result_t res_q, res_d;
	logic [lcsp_pkg::MAP_AW-1:0] clr_q;

	lcsp_pkg::map_t    map_mem [lcsp_pkg::MAP_DEPTH];
	lcsp_pkg::map_t    map_rd_q;
	logic              map_we;
	logic [lcsp_pkg::MAP_AW-1:0] map_wa;
	lcsp_pkg::map_t    map_wd;

	lcsp_pkg::cmd_t    cmd;
	lcsp_pkg::scan_t   fire_carry;
	lcsp_pkg::scan_t   carries [N];
	lcsp_pkg::entry_t  entries [N];

	logic fire, commit_go, accept, cid_ok, clr_last;

	assign accept       = item_valid && !item_stall;
	assign cid_ok       = 32'(item_q.client_id) < 32'(lcsp_pkg::MAX_CLIENTS);
	assign clr_last     = clr_q == lcsp_pkg::MAP_AW'(lcsp_pkg::MAP_DEPTH - 1);
	assign result_valid = res_vld_q;
	assign result       = res_q;

	always_comb begin
		fire_carry     = '0;
		fire_carry.vld = fire;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		lcsp_pkg::scan_t  cin;
		lcsp_pkg::entry_t nxt;
		if (i == 0) begin : g_head
			assign cin = fire_carry;
		end else begin : g_body
			assign cin = carries[i-1];
		end
		if (i == N - 1) begin : g_tail
			assign nxt = entries[i];
		end else begin : g_mid
			assign nxt = entries[i+1];
		end
		lcsp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (lcsp_pkg::SRV_IW'(i)),
			.total      (total_q),
			.key_addr   (key_addr_q),
			.key_port   (key_port_q),
			.cmd        (cmd),
			.next_entry (nxt),
			.carry_in   (cin),
			.carry_out  (carries[i]),
			.entry      (entries[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lcsp_pkg::ST_CLEAR:  if (clr_last) state_d = lcsp_pkg::ST_IDLE;
			lcsp_pkg::ST_IDLE:   if (item_valid) state_d = lcsp_pkg::ST_KEY;
			lcsp_pkg::ST_KEY:    state_d = lcsp_pkg::ST_FIRE;
			lcsp_pkg::ST_FIRE:   state_d = lcsp_pkg::ST_SCAN;
			lcsp_pkg::ST_SCAN:   if (carries[N-1].vld) state_d = lcsp_pkg::ST_COMMIT;
			lcsp_pkg::ST_COMMIT: if (!res_vld_q || !result_stall) state_d = lcsp_pkg::ST_IDLE;
			default:             state_d = lcsp_pkg::ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		item_stall = state_q != lcsp_pkg::ST_IDLE;
		fire       = state_q == lcsp_pkg::ST_FIRE;
		commit_go  = state_q == lcsp_pkg::ST_COMMIT && (!res_vld_q || !result_stall);
	end

	// update decision for the word in work
	always_comb begin
		cmd        = '{op: lcsp_pkg::CMD_NONE, pos: '0};
		res_d      = '0;
		map_we     = 1'b0;
		map_wa     = item_q.client_id[lcsp_pkg::MAP_AW-1:0];
		map_wd     = '0;
		total_d    = total_q;
		if (state_q == lcsp_pkg::ST_CLEAR) begin
			map_we = 1'b1;
			map_wa = clr_q;
		end else if (commit_go) begin
			case (item_q.kind)
				lcsp_pkg::KIND_REGISTER: begin
					if (scan_q.hit) begin
						cmd = '{op: lcsp_pkg::CMD_WRITE, pos: scan_q.hit_idx};
					end else if (32'(total_q) >= 32'(N)) begin
						res_d.status = lcsp_pkg::STATUS_FULL;
					end else begin
						cmd     = '{op: lcsp_pkg::CMD_WRITE,
							pos: total_q[lcsp_pkg::SRV_IW-1:0]};
						total_d = total_q + lcsp_pkg::SRV_CW'(1);
					end
				end
				lcsp_pkg::KIND_REQUEST: begin
					if (total_q == '0) begin
						res_d.status = lcsp_pkg::STATUS_NO_SERVERS;
					end else begin
						cmd               = '{op: lcsp_pkg::CMD_INC, pos: scan_q.best_idx};
						res_d.chosen_addr = scan_q.best_addr;
						res_d.chosen_port = scan_q.best_port;
						if (cid_ok) begin
							map_we = 1'b1;
							map_wd = '{mapped: 1'b1, addr: scan_q.best_addr,
								port: scan_q.best_port};
						end
					end
				end
				lcsp_pkg::KIND_DEREGISTER: begin
					if (scan_q.hit) begin
						cmd     = '{op: lcsp_pkg::CMD_SHIFT, pos: scan_q.hit_idx};
						total_d = total_q - lcsp_pkg::SRV_CW'(1);
					end
				end
				lcsp_pkg::KIND_RELEASE: begin
					if (cid_ok && mapped_q) begin
						map_we = 1'b1;
						if (scan_q.hit) begin
							cmd = '{op: lcsp_pkg::CMD_DEC, pos: scan_q.hit_idx};
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lcsp_pkg::ST_CLEAR;
			total_q   <= '0;
			res_vld_q <= 1'b0;
			clr_q     <= '0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			if (state_q == lcsp_pkg::ST_CLEAR && !clr_last) begin
				clr_q <= clr_q + lcsp_pkg::MAP_AW'(1);
			end
			if (commit_go) begin
				res_vld_q <= 1'b1;
			end else if (!result_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		// a release looks up the server its client was mapped to
		if (state_q == lcsp_pkg::ST_KEY) begin
			mapped_q <= map_rd_q.mapped;
			if (item_q.kind == lcsp_pkg::KIND_RELEASE) begin
				key_addr_q <= map_rd_q.addr;
				key_port_q <= map_rd_q.port;
			end else begin
				key_addr_q <= item_q.server_addr;
				key_port_q <= item_q.server_port;
			end
		end
		if (state_q == lcsp_pkg::ST_SCAN && carries[N-1].vld) begin
			scan_q <= carries[N-1];
		end
		if (commit_go) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		map_rd_q <= map_mem[item.client_id[lcsp_pkg::MAP_AW-1:0]];
	end

endmodule

/* tb/sv/picker_check_pkg.sv */
`timescale 1ns / 1ps
package picker_check_pkg;

	import lcsp_pkg::*;

	localparam int LOAD_CEIL = (1 << LOAD_W) - 1;

	class load_scoreboard;
		logic [31:0]       srv_addr [MAX_SERVERS];
		logic [15:0]       srv_port [MAX_SERVERS];
		logic [LOAD_W-1:0] srv_load [MAX_SERVERS];
		int                srv_count;
		bit                cl_mapped [MAP_DEPTH];
		logic [31:0]       cl_addr [MAP_DEPTH];
		logic [15:0]       cl_port [MAP_DEPTH];
		result_t           awaited [$];
		int errors, checked, n_ok, n_empty, n_full, n_ceiling, n_remap, n_stale;

		function new();
			srv_count = 0;
			errors = 0;
			checked = 0;
			n_ok = 0;
			n_empty = 0;
			n_full = 0;
			n_ceiling = 0;
			n_remap = 0;
			n_stale = 0;
		endfunction

		function int find_server(logic [31:0] a, logic [15:0] p);
			for (int i = 0; i < srv_count; i++)
				if (srv_addr[i] == a && srv_port[i] == p)
					return i;
			return srv_count;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// advance the server table by one accepted word and queue its result
		function void note_word(item_t w);
			result_t r;
			int      pos;
			int      best;
			r = '0;
			case (w.kind)
				KIND_REGISTER: begin
					pos = find_server(w.server_addr, w.server_port);
					if (pos < srv_count) begin
						srv_load[pos] = '0;
					end else if (srv_count >= MAX_SERVERS) begin
						r.status = STATUS_FULL;
					end else begin
						srv_addr[srv_count] = w.server_addr;
						srv_port[srv_count] = w.server_port;
						srv_load[srv_count] = '0;
						srv_count++;
					end
				end
				KIND_REQUEST: begin
					if (srv_count == 0) begin
						r.status = STATUS_NO_SERVERS;
					end else begin
						best = 0;
						for (int i = 1; i < srv_count; i++)
							if (srv_load[i] < srv_load[best])
								best = i;
						if (srv_load[best] != LOAD_CEIL)
							srv_load[best]++;
						else
							n_ceiling++;
						r.chosen_addr = srv_addr[best];
						r.chosen_port = srv_port[best];
						if (int'(w.client_id) < MAX_CLIENTS) begin
							if (cl_mapped[w.client_id])
								n_remap++;
							cl_mapped[w.client_id] = 1'b1;
							cl_addr[w.client_id] = srv_addr[best];
							cl_port[w.client_id] = srv_port[best];
						end
					end
				end
				KIND_DEREGISTER: begin
					pos = find_server(w.server_addr, w.server_port);
					if (pos < srv_count) begin
						// close the hole, keep the order of the rest
						for (int i = pos; i + 1 < srv_count; i++) begin
							srv_addr[i] = srv_addr[i+1];
							srv_port[i] = srv_port[i+1];
							srv_load[i] = srv_load[i+1];
						end
						srv_count--;
					end
				end
				default: begin
					if (int'(w.client_id) < MAX_CLIENTS && cl_mapped[w.client_id]) begin
						cl_mapped[w.client_id] = 1'b0;
						pos = find_server(cl_addr[w.client_id], cl_port[w.client_id]);
						if (pos < srv_count) begin
							if (srv_load[pos] != 0)
								srv_load[pos]--;
						end else begin
							n_stale++;
						end
					end
				end
			endcase
			awaited.insert(awaited.size(), r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t ns: result with nothing expected, got status %0d addr %h port %h",
					$time, got.status, got.chosen_addr, got.chosen_port);
				return;
			end
			want = awaited.pop_front();
			checked++;
			case (want.status)
				STATUS_OK:         n_ok++;
				STATUS_NO_SERVERS: n_empty++;
				default:           n_full++;
			endcase
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("chosen_addr", want.chosen_addr, got.chosen_addr);
			compare_field("chosen_port", 32'(want.chosen_port), 32'(got.chosen_port));
		endfunction
	endclass

endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;

	import lcsp_pkg::*;
	import picker_check_pkg::*;

	localparam int IDLE_LIMIT    = 5000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int POOL          = 24;
	localparam int PHASE_WORDS   = 130;
	localparam int LOAD_RUN      = 20;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	load_scoreboard sb = new();

	logic [31:0] pool_addr [POOL];
	logic [15:0] pool_port [POOL];
	int          burst_left = 0;
	int          idle_cycles = 0;
	bit          hold_off_req = 1'b0;
	int          hold_offs_done = 0;

	least_connections_server_picker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: stall in modes of random length, or hold off on request
	initial begin : receiver_side
		int mode;
		int left;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				hold_offs_done++;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(16, 96);
				end
				left--;
				case (mode)
					0:       result_stall <= 1'b0;
					1:       result_stall <= ($urandom_range(0, 3) == 0);
					2:       result_stall <= ($urandom_range(0, 9) < 7);
					default: result_stall <= (left % 3 == 0);
				endcase
			end
		end
	end

	function automatic item_t compose(logic [1:0] k, logic [31:0] a, logic [15:0] p,
			logic [9:0] c);
		item_t w;
		w.kind = k;
		w.server_addr = a;
		w.server_port = p;
		w.client_id = c;
		return w;
	endfunction

	function automatic item_t random_word(int w_reg, int w_req, int w_drop, int w_rel);
		int          r;
		int          s;
		logic [1:0]  k;
		logic [31:0] a;
		logic [15:0] p;
		logic [9:0]  c;
		r = $urandom_range(0, w_reg + w_req + w_drop + w_rel - 1);
		if (r < w_reg)
			k = KIND_REGISTER;
		else if (r < w_reg + w_req)
			k = KIND_REQUEST;
		else if (r < w_reg + w_req + w_drop)
			k = KIND_DEREGISTER;
		else
			k = KIND_RELEASE;
		s = $urandom_range(0, POOL - 1);
		a = pool_addr[s];
		p = pool_port[s];
		if ($urandom_range(0, 9) == 0) begin
			a = $urandom;
			p = 16'($urandom);
		end
		// keep most clients in a small set so releases find mappings
		case ($urandom_range(0, 9))
			0:       c = 10'($urandom);
			1:       c = $urandom_range(0, 1) ? '1 : '0;
			default: c = 10'($urandom_range(0, 31));
		endcase
		return compose(k, a, p, c);
	endfunction

	task automatic offer(input item_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				item_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		burst_left--;
		@(negedge clk);
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sb.note_word(w);
	endtask

	// hold the sender until every queued result has come back
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int weights [4][4];
		weights = '{'{8, 3, 1, 2}, '{2, 6, 1, 5}, '{1, 3, 6, 2}, '{3, 4, 2, 3}};
		for (int i = 0; i < POOL; i++) begin
			pool_addr[i] = $urandom;
			pool_port[i] = 16'($urandom);
		end
		pool_addr[0] = '0;
		pool_port[0] = '0;
		pool_addr[1] = '1;
		pool_port[1] = '1;
		// entries that differ only in port, and entries that differ only in address
		pool_addr[3] = pool_addr[2];
		pool_port[5] = pool_port[4];

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		offer(compose(KIND_REQUEST, '0, '0, 10'd0));
		offer(compose(KIND_RELEASE, '0, '0, '1));
		offer(compose(KIND_DEREGISTER, '1, '1, '0));
		for (int i = 0; i < 4; i++)
			offer(compose(KIND_REGISTER, pool_addr[i], pool_port[i], '0));
		offer(compose(KIND_REQUEST, '0, '0, 10'd0));
		offer(compose(KIND_REQUEST, '0, '0, '1));
		offer(compose(KIND_REQUEST, '0, '0, 10'd5));
		offer(compose(KIND_REQUEST, '0, '0, 10'd6));
		offer(compose(KIND_REQUEST, '0, '0, 10'd5));
		offer(compose(KIND_REGISTER, pool_addr[0], pool_port[0], '0));
		offer(compose(KIND_REQUEST, '0, '0, 10'd7));
		offer(compose(KIND_DEREGISTER, pool_addr[1], pool_port[1], '0));
		offer(compose(KIND_RELEASE, '0, '0, '1));
		offer(compose(KIND_RELEASE, '0, '0, 10'd0));
		offer(compose(KIND_RELEASE, '0, '0, 10'd7));
		offer(compose(KIND_RELEASE, '0, '0, 10'd5));
		offer(compose(KIND_RELEASE, '0, '0, 10'd5));

		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 1)
				hold_off_req = 1'b1;
			if (ph == 2)
				drain();
			repeat (PHASE_WORDS)
				offer(random_word(weights[ph][0], weights[ph][1], weights[ph][2],
					weights[ph][3]));
		end

		// empty the table, then load one server ahead of a second one
		drain();
		while (sb.srv_count > 0)
			offer(compose(KIND_DEREGISTER, sb.srv_addr[0], sb.srv_port[0], '0));
		offer(compose(KIND_REGISTER, pool_addr[4], pool_port[4], '0));
		repeat (LOAD_RUN)
			offer(compose(KIND_REQUEST, '0, '0, 10'($urandom)));
		offer(compose(KIND_REGISTER, pool_addr[5], pool_port[5], '0));
		repeat (6)
			offer(compose(KIND_REQUEST, '0, '0, 10'($urandom)));
		repeat (16)
			offer(compose(KIND_RELEASE, '0, '0, 10'($urandom)));
		repeat (6)
			offer(compose(KIND_REQUEST, '0, '0, 10'($urandom)));

		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("checked %0d results: %0d ok, %0d with no server, %0d with a full table",
			sb.checked, sb.n_ok, sb.n_empty, sb.n_full);
		$display("remapped clients %0d, releases to departed servers %0d, holds %0d",
			sb.n_remap, sb.n_stale, hold_offs_done);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
design/lcsp_pkg.sv
design/lcsp_cell.sv
design/least_connections_server_picker.sv
tb/sv/picker_check_pkg.sv
tb/sv/testbench.sv
